// ===== rtl/slcr_pkg.sv =====
// Shared types and constants for the serial line channel register block.
`timescale 1ns / 1ps

package slcr_pkg;

   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // Register bit positions of the standard layout.
   localparam logic [15:0] RCSR_READER_EN  = 16'h0001;
   localparam logic [15:0] CSR_INT_EN      = 16'h0040;
   localparam logic [15:0] CSR_DONE_READY  = 16'h0080;
   localparam logic [15:0] RBUF_EMPTY_READ = 16'hC000;

   localparam logic [7:0]  BREAK_KEY_RESET  = 8'd0;
   localparam logic [1:0]  BREAK_RESP_RESET = 2'd0;
   localparam logic [15:0] RCSR_MASK_RESET  = 16'h0040;
   localparam logic [15:0] XCSR_MASK_RESET  = 16'h0045;
   localparam logic [15:0] TX_DELAY_RESET   = 16'd1000;

   typedef enum logic [2:0] {
      OP_BUS_READ  = 3'd0,
      OP_BUS_WRITE = 3'd1,
      OP_RX_CHAR   = 3'd2,
      OP_TICK      = 3'd3,
      OP_BUS_RESET = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      REG_RCSR = 2'd0,
      REG_RBUF = 2'd1,
      REG_XCSR = 2'd2,
      REG_XBUF = 2'd3
   } reg_offset_type;

   typedef enum logic [1:0] {
      BRK_NONE = 2'd0,
      BRK_HALT = 2'd1,
      BRK_BOOT = 2'd2
   } break_resp_type;

   typedef enum logic [2:0] {
      CSR_BREAK_KEY  = 3'd0,
      CSR_BREAK_RESP = 3'd1,
      CSR_CONSOLE    = 3'd2,
      CSR_RCSR_MASK  = 3'd3,
      CSR_XCSR_MASK  = 3'd4,
      CSR_TX_DELAY   = 3'd5
   } csr_index_type;

endpackage

// ===== rtl/serial_line_channel_registers_unit.sv =====
// Top level of the serial line channel register block (RCSR, RBUF, XCSR, XBUF).
`timescale 1ns / 1ps

// One serial line channel with the classic four register words. Every request
// transaction is one bus read, bus write, received character, transmitter tick
// or bus reset, and it produces exactly one response transaction, registered
// and presented in the cycle after its request was accepted. The block takes
// one request per clock unless the held response stalls: a new request is
// accepted whenever the output register is empty or is being drained in the
// same cycle. The receive FIFO is a 16 entry by 8 bit synchronous memory whose
// head entry is read into a register when an RBUF read pops it. Received
// characters that find the FIFO full are dropped. On a console channel the
// break key gives a halt or boot pulse, or is swallowed; on a loopback channel
// each transmitted character is fed back into the receiver. After an XBUF write
// the first tick with no delay left sends the character, then tx_delay_ff ticks
// are skipped. The user must write configuration registers through the csr port
// only while no transaction is in flight; the block does not enforce this.
module serial_line_channel_registers_unit
   import slcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // reg_offset[1:0], write_data[17:2], rx_char[25:18],
                                    // power_ok[26], zero fill
   input  logic [2:0]  req_tuser,   // operation[2:0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_data[15:0], rx_irq[16], tx_irq[17], tx_valid[18],
                                    // tx_char[26:19], halt_pulse[27], boot_pulse[28], zero fill
   // Configuration port.
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   // Configuration registers.
   logic [7:0]  break_key_ff;
   logic [1:0]  break_resp_ff;
   logic        console_ff;
   logic [15:0] rcsr_mask_ff;
   logic [15:0] xcsr_mask_ff;
   logic [15:0] tx_delay_ff;

   // Channel state.
   logic [15:0]      rcsr_ff, rcsr_in;
   logic [15:0]      xcsr_ff, xcsr_in;
   logic [7:0]       xbuf_ff, xbuf_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pending_ff, pending_in;
   logic [15:0]      wait_ff, wait_in;

   // Receive FIFO storage and its registered read port.
   logic [7:0]       fifo_mem [FIFO_DEPTH];
   logic [7:0]       mem_q_ff;
   logic             mem_we;
   logic             mem_re;
   logic [PTR_W-1:0] wr_idx;
   logic [7:0]       wr_char;

   // Response register.
   logic        out_valid_ff;
   logic        out_pop_ff,    out_pop_in;
   logic [15:0] out_rd_ff,     out_rd_in;
   logic        out_rxirq_ff,  out_rxirq_in;
   logic        out_txirq_ff,  out_txirq_in;
   logic        out_txv_ff,    out_txv_in;
   logic [7:0]  out_txc_ff,    out_txc_in;
   logic        out_halt_ff,   out_halt_in;
   logic        out_boot_ff,   out_boot_in;

   // Request fields.
   op_type         op;
   reg_offset_type reg_sel;
   logic [15:0]    wdata;
   logic [7:0]     rx_char;
   logic           power_ok;
   logic           accept;

   assign op       = op_type'(req_tuser);
   assign reg_sel  = reg_offset_type'(req_tdata[1:0]);
   assign wdata    = req_tdata[17:2];
   assign rx_char  = req_tdata[25:18];
   assign power_ok = req_tdata[26];

   // The output register is refilled whenever it is empty or drains this cycle.
   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         break_key_ff  <= BREAK_KEY_RESET;
         break_resp_ff <= BREAK_RESP_RESET;
         console_ff    <= 1'b1;
         rcsr_mask_ff  <= RCSR_MASK_RESET;
         xcsr_mask_ff  <= XCSR_MASK_RESET;
         tx_delay_ff   <= TX_DELAY_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_BREAK_KEY:  break_key_ff  <= csr_wdata[7:0];
            CSR_BREAK_RESP: break_resp_ff <= csr_wdata[1:0];
            CSR_CONSOLE:    console_ff    <= csr_wdata[0];
            CSR_RCSR_MASK:  rcsr_mask_ff  <= csr_wdata;
            CSR_XCSR_MASK:  xcsr_mask_ff  <= csr_wdata;
            CSR_TX_DELAY:   tx_delay_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next-state and response computation for the accepted transaction. The
   // RBUF word itself needs no register: every RBUF read either pops the FIFO
   // head, whose data arrives through the memory read register, or returns the
   // empty-read pattern.
   always_comb begin
      logic             take;
      logic [7:0]       ch;
      logic [CNT_W:0]   wr_sum;

      rcsr_in      = rcsr_ff;
      xcsr_in      = xcsr_ff;
      xbuf_in      = xbuf_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pending_in   = pending_ff;
      wait_in      = wait_ff;
      mem_re       = 1'b0;
      out_pop_in   = 1'b0;
      out_rd_in    = 16'd0;
      out_rxirq_in = 1'b0;
      out_txirq_in = 1'b0;
      out_txv_in   = 1'b0;
      out_txc_in   = 8'd0;
      out_halt_in  = 1'b0;
      out_boot_in  = 1'b0;
      take         = 1'b0;
      ch           = rx_char;

      case (op)
         OP_BUS_READ: begin
            case (reg_sel)
               REG_RCSR: out_rd_in = rcsr_ff;
               REG_RBUF: begin
                  if (count_ff != '0) begin
                     mem_re     = 1'b1;
                     out_pop_in = 1'b1;
                     head_in    = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : head_ff + PTR_W'(1);
                     count_in   = count_ff - CNT_W'(1);
                     rcsr_in    = rcsr_ff & ~CSR_DONE_READY;
                  end else begin
                     out_rd_in = RBUF_EMPTY_READ;
                  end
               end
               REG_XCSR: out_rd_in = xcsr_ff;
               REG_XBUF: out_rd_in = {8'd0, xbuf_ff};
               default: ;
            endcase
         end
         OP_BUS_WRITE: begin
            case (reg_sel)
               REG_RCSR: begin
                  rcsr_in = (rcsr_ff & ~rcsr_mask_ff) | (wdata & rcsr_mask_ff);
                  if ((wdata & RCSR_READER_EN) != '0) begin
                     rcsr_in = rcsr_in & ~CSR_DONE_READY;
                  end
                  out_rxirq_in = ((wdata & CSR_INT_EN) != '0) &&
                                 ((rcsr_ff & CSR_INT_EN) == '0) &&
                                 ((rcsr_in & CSR_DONE_READY) != '0);
               end
               REG_XCSR: begin
                  xcsr_in = (xcsr_ff & ~xcsr_mask_ff) | (wdata & xcsr_mask_ff);
                  out_txirq_in = ((wdata & CSR_INT_EN) != '0) &&
                                 ((xcsr_ff & CSR_INT_EN) == '0) &&
                                 ((xcsr_in & CSR_DONE_READY) != '0);
               end
               REG_XBUF: begin
                  xcsr_in    = xcsr_ff & ~CSR_DONE_READY;
                  xbuf_in    = wdata[7:0];
                  pending_in = 1'b1;
               end
               default: ;   // RBUF writes are ignored.
            endcase
         end
         OP_RX_CHAR: begin
            take = 1'b1;
         end
         OP_TICK: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 16'd1;
            end else if (pending_ff) begin
               pending_in   = 1'b0;
               out_txv_in   = 1'b1;
               out_txc_in   = xbuf_ff;
               xcsr_in      = xcsr_ff | CSR_DONE_READY;
               out_txirq_in = (xcsr_ff & CSR_INT_EN) != '0;
               wait_in      = tx_delay_ff;
               // A loopback channel hears its own transmitted character.
               take         = !console_ff;
               ch           = xbuf_ff;
            end
         end
         OP_BUS_RESET: begin
            rcsr_in = rcsr_ff & ~(CSR_INT_EN | CSR_DONE_READY);
            xcsr_in = CSR_DONE_READY;
         end
         default: ;
      endcase

      // Receive path shared by line characters and loopback.
      wr_sum  = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
      if (wr_sum >= (CNT_W + 1)'(FIFO_DEPTH)) begin
         wr_sum = wr_sum - (CNT_W + 1)'(FIFO_DEPTH);
      end
      wr_idx  = wr_sum[PTR_W-1:0];
      wr_char = ch;
      mem_we  = 1'b0;
      if (take && power_ok) begin
         if (console_ff && (ch == break_key_ff)) begin
            out_halt_in = (break_resp_ff == BRK_HALT);
            out_boot_in = (break_resp_ff == BRK_BOOT);
         end else if (count_ff < CNT_W'(FIFO_DEPTH)) begin
            mem_we       = 1'b1;
            count_in     = count_ff + CNT_W'(1);
            rcsr_in      = rcsr_in | CSR_DONE_READY;
            out_rxirq_in = (rcsr_in & CSR_INT_EN) != '0;
         end
      end
   end

   // Receive FIFO memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (accept && mem_we) begin
         fifo_mem[wr_idx] <= wr_char;
      end
      if (accept && mem_re) begin
         mem_q_ff <= fifo_mem[head_ff];
      end
   end

   // Channel state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         rcsr_ff    <= '0;
         xcsr_ff    <= CSR_DONE_READY;
         xbuf_ff    <= '0;
         head_ff    <= '0;
         count_ff   <= '0;
         pending_ff <= 1'b0;
         wait_ff    <= '0;
      end else if (accept) begin
         rcsr_ff    <= rcsr_in;
         xcsr_ff    <= xcsr_in;
         xbuf_ff    <= xbuf_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
         wait_ff    <= wait_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_pop_ff   <= out_pop_in;
         out_rd_ff    <= out_rd_in;
         out_rxirq_ff <= out_rxirq_in;
         out_txirq_ff <= out_txirq_in;
         out_txv_ff   <= out_txv_in;
         out_txc_ff   <= out_txc_in;
         out_halt_ff  <= out_halt_in;
         out_boot_ff  <= out_boot_in;
      end
   end

   // A popping RBUF read takes its data straight from the memory read register,
   // which holds while the response waits.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_boot_ff, out_halt_ff, out_txc_ff, out_txv_ff,
                        out_txirq_ff, out_rxirq_ff,
                        out_pop_ff ? {8'd0, mem_q_ff} : out_rd_ff};

endmodule
